// File: design/i2cbm_pkg.sv
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types and constants for the bit-level i2c bus master sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbm_pkg;

    localparam int unsigned KIND_W  = 3;
    localparam int unsigned PHASE_W = 6;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ACKM_W  = 2;

    // command codes
    localparam logic [KIND_W-1:0] CMD_NONE  = 3'd0;
    localparam logic [KIND_W-1:0] CMD_START = 3'd1;
    localparam logic [KIND_W-1:0] CMD_STOP  = 3'd2;
    localparam logic [KIND_W-1:0] CMD_SEND  = 3'd3;
    localparam logic [KIND_W-1:0] CMD_WAIT  = 3'd4;
    localparam logic [KIND_W-1:0] CMD_READ  = 3'd5;
    localparam logic [KIND_W-1:0] CMD_PROBE = 3'd6;

    // acknowledge modes after a read
    localparam logic [ACKM_W-1:0] ACKM_NACK = 2'd0;
    localparam logic [ACKM_W-1:0] ACKM_NONE = 2'd2;

    // write direction bit or-ed into the probe address
    localparam logic [BYTE_W-1:0] WR_BIT = 8'h00;

    // sequence lengths in ticks
    localparam logic [PHASE_W-1:0] LEN_START    = 6'd3;
    localparam logic [PHASE_W-1:0] LEN_STOP     = 6'd1;
    localparam logic [PHASE_W-1:0] LEN_SEND     = 6'd24;
    localparam logic [PHASE_W-1:0] LEN_WAIT     = 6'd3;
    localparam logic [PHASE_W-1:0] LEN_READ     = 6'd16;
    localparam logic [PHASE_W-1:0] LEN_READ_ACK = 6'd19;
    localparam logic [PHASE_W-1:0] LEN_PROBE    = 6'd31;

    // probe segment boundaries
    localparam logic [PHASE_W-1:0] PRB_SEND = 6'd3;
    localparam logic [PHASE_W-1:0] PRB_WAIT = 6'd27;
    localparam logic [PHASE_W-1:0] PRB_STOP = 6'd30;

    // last slot of the last bit of a byte send
    localparam logic [PHASE_W-1:0] SEND_LAST  = LEN_SEND - 6'd1;
    localparam logic [PHASE_W-1:0] PRB_S_LAST = PRB_WAIT - 6'd1;

    // ack phase slots of a read
    localparam logic [PHASE_W-1:0] RD_ACK0 = 6'd16;
    localparam logic [PHASE_W-1:0] RD_ACK1 = 6'd17;

    typedef struct packed {
        logic [KIND_W-1:0]  cmd;
        logic [PHASE_W-1:0] phase;
        logic [1:0]         slot;      // phase modulo three
        logic [BYTE_W-1:0]  shift_out;
        logic [BYTE_W-1:0]  shift_in;
        logic [ACKM_W-1:0]  ack_mode;
        logic               ack;
        logic               scl;
        logic               sda;
    } t_state;

    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_bit;
    } t_result;

endpackage

`default_nettype wire

// File: design/i2cbm_if.sv
// ----------------------------------------------------------------------------
// i2cbm_if
// Valid/ready channels for bus ticks in and bus drive results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cbm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic [1:0] ack_mode;
    logic       sda_in;

    modport source (output valid, kind, tx_byte, ack_mode, sda_in, input ready);
    modport sink   (input valid, kind, tx_byte, ack_mode, sda_in, output ready);
endinterface

interface i2cbm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_bit;

    modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_bit,
                    input ready);
    modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_bit,
                    output ready);
endinterface

`default_nettype wire

// File: design/i2cbm_slot.sv
// ----------------------------------------------------------------------------
// i2cbm_slot
// One bus tick: launches a command when idle, drives the current delay slot,
// samples sda and advances the sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbm_slot (
    input  var i2cbm_pkg::t_state  i_cur,
    input  var logic [2:0]         i_kind,
    input  var logic [7:0]         i_tx_byte,
    input  var logic [1:0]         i_ack_mode,
    input  var logic               i_sda_in,
    output var i2cbm_pkg::t_state  o_nxt,
    output var i2cbm_pkg::t_result o_res
);
    import i2cbm_pkg::*;

    logic               launch;
    logic               run;
    logic               rel;
    logic               done;
    logic               seg_start;
    logic               seg_send;
    logic               seg_wait;
    logic               seg_stop;
    logic               send_last;
    logic [PHASE_W-1:0] len;
    t_state             s;
    t_state             w;

    always_comb begin
        launch = (i_cur.cmd == CMD_NONE) && (i_kind != CMD_NONE) && (i_kind <= CMD_PROBE);
        run    = (i_cur.cmd != CMD_NONE) || launch;

        s = i_cur;
        if (launch) begin
            s.cmd       = i_kind;
            s.phase     = '0;
            s.slot      = '0;
            s.shift_out = i_tx_byte | ((i_kind == CMD_PROBE) ? WR_BIT : 8'h00);
            s.ack_mode  = i_ack_mode;
            if (i_kind == CMD_READ) begin
                s.shift_in = '0;
            end
        end

        unique case (s.cmd)
            CMD_START: len = LEN_START;
            CMD_STOP:  len = LEN_STOP;
            CMD_SEND:  len = LEN_SEND;
            CMD_WAIT:  len = LEN_WAIT;
            CMD_READ:  len = (s.ack_mode == ACKM_NONE) ? LEN_READ : LEN_READ_ACK;
            CMD_PROBE: len = LEN_PROBE;
            default:   len = LEN_STOP;
        endcase

        seg_start = (s.cmd == CMD_START) || ((s.cmd == CMD_PROBE) && (s.phase < PRB_SEND));
        seg_send  = (s.cmd == CMD_SEND) || ((s.cmd == CMD_PROBE) && (s.phase >= PRB_SEND)
                    && (s.phase < PRB_WAIT));
        seg_wait  = (s.cmd == CMD_WAIT) || ((s.cmd == CMD_PROBE) && (s.phase >= PRB_WAIT)
                    && (s.phase < PRB_STOP));
        seg_stop  = (s.cmd == CMD_STOP) || ((s.cmd == CMD_PROBE) && (s.phase >= PRB_STOP));
        send_last = ((s.cmd == CMD_SEND) && (s.phase == SEND_LAST))
                 || ((s.cmd == CMD_PROBE) && (s.phase == PRB_S_LAST));

        // probe segments start on multiples of three, so the slot counter lines up
        w   = s;
        rel = 1'b0;
        if (seg_start) begin
            case (s.slot)
                2'd0: begin
                    w.scl = 1'b1;
                    w.sda = 1'b1;
                end
                2'd1: w.sda = 1'b0;
                default: w.scl = 1'b0;
            endcase
        end else if (seg_send) begin
            case (s.slot)
                2'd0: w.sda = s.shift_out[BYTE_W-1];
                2'd1: w.scl = 1'b1;
                default: begin
                    w.scl       = 1'b0;
                    w.shift_out = {s.shift_out[BYTE_W-2:0], 1'b0};
                    if (send_last) begin
                        w.sda = 1'b1;
                    end
                end
            endcase
        end else if (seg_wait) begin
            case (s.slot)
                2'd0: w.sda = 1'b1;
                2'd1: begin
                    w.scl = 1'b1;
                    w.ack = i_sda_in;
                end
                default: w.scl = 1'b0;
            endcase
        end else if (seg_stop) begin
            w.sda = 1'b0;
            w.scl = 1'b1;
            rel   = 1'b1;
        end else if (s.cmd == CMD_READ) begin
            if (s.phase < RD_ACK0) begin
                w.scl = ~s.phase[0];
                if (!s.phase[0]) begin
                    w.shift_in = {s.shift_in[BYTE_W-2:0], i_sda_in};
                end
            end else if (s.phase == RD_ACK0) begin
                w.sda = (s.ack_mode == ACKM_NACK);
            end else if (s.phase == RD_ACK1) begin
                w.scl = 1'b1;
            end else begin
                w.scl = 1'b0;
                rel   = 1'b1;
            end
        end

        done = ({1'b0, s.phase} + 7'd1) >= {1'b0, len};

        if (run) begin
            o_res.scl_out  = w.scl;
            o_res.sda_out  = w.sda;
            o_res.busy_res = 1'b1;
            o_res.done_res = done;
            o_res.rx_byte  = w.shift_in;
            o_res.ack_bit  = w.ack;

            o_nxt = w;
            if (rel) begin
                o_nxt.sda = 1'b1;
            end
            if (done) begin
                o_nxt.cmd   = CMD_NONE;
                o_nxt.phase = '0;
                o_nxt.slot  = '0;
            end else begin
                o_nxt.phase = s.phase + 6'd1;
                o_nxt.slot  = (s.slot == 2'd2) ? 2'd0 : s.slot + 2'd1;
            end
        end else begin
            o_res.scl_out  = i_cur.scl;
            o_res.sda_out  = i_cur.sda;
            o_res.busy_res = 1'b0;
            o_res.done_res = 1'b0;
            o_res.rx_byte  = i_cur.shift_in;
            o_res.ack_bit  = i_cur.ack;
            o_nxt          = i_cur;
        end
    end

endmodule

`default_nettype wire

// File: design/i2c_bit_level_master_top.sv
// the result of a tick is registered and shown in the cycle after the tick is accepted
// throughput: one tick per cycle while the consumer takes each result; the sequencer
//   state and the result register both update in the cycle a tick is accepted
// a waiting result does not stop the next tick while the consumer takes it
// reset: synchronous active-low, returns to idle with both lines released,
//   shift registers cleared and the acknowledge flag at no response
// ----------------------------------------------------------------------------
// i2c_bit_level_master_top
// Bit-level i2c bus master: one bus delay slot per accepted tick.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_bit_level_master_top (
    input  var logic      i_clk,
    input  var logic      i_rst_n,
    i2cbm_in_if.sink      i_in,
    i2cbm_out_if.source   o_out
);
    import i2cbm_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result r_res;
    t_result n_res;
    logic    r_out_valid;
    logic    accept;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    i2cbm_slot u_slot (
        .i_cur      (r_state),
        .i_kind     (i_in.kind),
        .i_tx_byte  (i_in.tx_byte),
        .i_ack_mode (i_in.ack_mode),
        .i_sda_in   (i_in.sda_in),
        .o_nxt      (n_state),
        .o_res      (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.cmd       <= CMD_NONE;
            r_state.phase     <= '0;
            r_state.slot      <= '0;
            r_state.shift_out <= '0;
            r_state.shift_in  <= '0;
            r_state.ack_mode  <= '0;
            r_state.ack       <= 1'b1;
            r_state.scl       <= 1'b1;
            r_state.sda       <= 1'b1;
            r_out_valid       <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.scl_out  = r_res.scl_out;
    assign o_out.sda_out  = r_res.sda_out;
    assign o_out.busy_res = r_res.busy_res;
    assign o_out.done_res = r_res.done_res;
    assign o_out.rx_byte  = r_res.rx_byte;
    assign o_out.ack_bit  = r_res.ack_bit;

endmodule

`default_nettype wire

// File: design/i2cbm_checker.sv
// ----------------------------------------------------------------------------
// i2cbm_checker
// Port-level checks on the bus master handshake and result flags.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbm_checker (
    input var logic       i_clk,
    input var logic       i_rst_n,
    input var logic       i_in_valid,
    input var logic       i_in_ready,
    input var logic       i_out_valid,
    input var logic       i_out_ready,
    input var logic       i_scl_out,
    input var logic       i_sda_out,
    input var logic       i_busy_res,
    input var logic       i_done_res,
    input var logic [7:0] i_rx_byte,
    input var logic       i_ack_bit
);

    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // an accepted beat always produces a result beat next cycle
    a_accept_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("accepted beat gave no result");

    // an empty result register never stalls the input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // completion only inside a running command
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_done_res) |-> i_busy_res)
        else $error("done without busy");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_scl_out)
        && $stable(i_sda_out) && $stable(i_rx_byte) && $stable(i_ack_bit)))
        else $error("stalled result changed");

endmodule

bind i2c_bit_level_master_top i2cbm_checker u_i2cbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_scl_out   (o_out.scl_out),
    .i_sda_out   (o_out.sda_out),
    .i_busy_res  (o_out.busy_res),
    .i_done_res  (o_out.done_res),
    .i_rx_byte   (o_out.rx_byte),
    .i_ack_bit   (o_out.ack_bit)
);

`default_nettype wire

// File: tb/i2c_bit_level_master_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bit_level_master_top_tb
// Drives bus phase ticks into the bit-level i2c master and checks every
// result beat against a cycle-by-tick model of the bus sequencer.
// ----------------------------------------------------------------------------

import i2cbm_pkg::*;

class bus_drive_scoreboard;
    logic [KIND_W-1:0]  cmd;
    logic [PHASE_W-1:0] phase;
    logic [BYTE_W-1:0]  sh_out;
    logic [BYTE_W-1:0]  sh_in;
    logic [ACKM_W-1:0]  ackm;
    logic               ack_flag;
    logic               scl;
    logic               sda;
    logic               rel;
    t_result            expected_drive[$];
    int                 mismatches;
    int                 beats_seen;

    function new();
        cmd        = CMD_NONE;
        phase      = '0;
        sh_out     = '0;
        sh_in      = '0;
        ackm       = '0;
        ack_flag   = 1'b1;
        scl        = 1'b1;
        sda        = 1'b1;
        rel        = 1'b0;
        mismatches = 0;
        beats_seen = 0;
    endfunction

    function bit idle();
        return cmd == CMD_NONE;
    endfunction

    function int pending();
        return expected_drive.size();
    endfunction

    function void do_start(int unsigned q);
        if (q == 0) begin
            sda = 1'b1;
            scl = 1'b1;
        end else if (q == 1) begin
            sda = 1'b0;
        end else begin
            scl = 1'b0;
        end
    endfunction

    function void do_stop();
        sda = 1'b0;
        scl = 1'b1;
        rel = 1'b1;
    endfunction

    function void do_send(int unsigned q);
        int unsigned bitn;
        int unsigned r;
        bitn = q / 3;
        r    = q % 3;
        if (r == 0) begin
            sda = sh_out[7];
        end else if (r == 1) begin
            scl = 1'b1;
        end else begin
            scl = 1'b0;
            // last bit lets go of sda on its falling slot
            if (bitn == 7) sda = 1'b1;
            sh_out = sh_out << 1;
        end
    endfunction

    function void do_wait_ack(int unsigned q, logic s);
        if (q == 0) begin
            sda = 1'b1;
        end else if (q == 1) begin
            scl      = 1'b1;
            ack_flag = s;
        end else begin
            scl = 1'b0;
        end
    endfunction

    function void do_read(int unsigned q, logic s);
        if (q < 16) begin
            if (q[0] == 1'b0) begin
                scl   = 1'b1;
                sh_in = {sh_in[6:0], s};
            end else begin
                scl = 1'b0;
            end
        end else if (q == 16) begin
            sda = (ackm == ACKM_NACK) ? 1'b1 : 1'b0;
        end else if (q == 17) begin
            scl = 1'b1;
        end else begin
            scl = 1'b0;
            rel = 1'b1;
        end
    endfunction

    function int unsigned seq_len();
        case (cmd)
            CMD_START: return LEN_START;
            CMD_STOP:  return LEN_STOP;
            CMD_SEND:  return LEN_SEND;
            CMD_WAIT:  return LEN_WAIT;
            CMD_READ:  return (ackm == ACKM_NONE) ? LEN_READ : LEN_READ_ACK;
            CMD_PROBE: return LEN_PROBE;
            default:   return 1;
        endcase
    endfunction

    function void note_tick(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] tx,
                            logic [ACKM_W-1:0] am, logic s);
        t_result     r;
        int unsigned p;
        bit          done;
        if (cmd == CMD_NONE) begin
            if (kind >= CMD_START && kind <= CMD_PROBE) begin
                cmd    = kind;
                phase  = '0;
                sh_out = tx;
                if (kind == CMD_PROBE) sh_out = tx | WR_BIT;
                ackm = am;
                if (kind == CMD_READ) sh_in = '0;
            end else begin
                r.scl_out  = scl;
                r.sda_out  = sda;
                r.busy_res = 1'b0;
                r.done_res = 1'b0;
                r.rx_byte  = sh_in;
                r.ack_bit  = ack_flag;
                expected_drive.push_back(r);
                return;
            end
        end
        p   = phase;
        rel = 1'b0;
        case (cmd)
            CMD_START: do_start(p);
            CMD_STOP:  do_stop();
            CMD_SEND:  do_send(p);
            CMD_WAIT:  do_wait_ack(p, s);
            CMD_READ:  do_read(p, s);
            CMD_PROBE: begin
                if (p < PRB_SEND)      do_start(p);
                else if (p < PRB_WAIT) do_send(p - PRB_SEND);
                else if (p < PRB_STOP) do_wait_ack(p - PRB_WAIT, s);
                else                   do_stop();
            end
            default: ;
        endcase
        done = (p + 1 >= seq_len());
        r.scl_out  = scl;
        r.sda_out  = sda;
        r.busy_res = 1'b1;
        r.done_res = done;
        r.rx_byte  = sh_in;
        r.ack_bit  = ack_flag;
        expected_drive.push_back(r);
        // stop and ack release sda only after the tick
        if (rel) sda = 1'b1;
        rel = 1'b0;
        if (done) begin
            cmd   = CMD_NONE;
            phase = '0;
        end else begin
            phase = phase + 1'b1;
        end
    endfunction

    task report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 40) $display("mismatch: %s", msg);
    endtask

    task cmp_field(string fname, logic [7:0] want, logic [7:0] got);
        if (got !== want)
            report_mismatch($sformatf("beat %0d %s expected %0h got %0h",
                                      beats_seen, fname, want, got));
    endtask

    task check_drive(t_result got);
        t_result want;
        if (expected_drive.size() == 0) begin
            report_mismatch($sformatf("beat %0d arrived with no tick pending", beats_seen));
            beats_seen++;
            return;
        end
        want = expected_drive.pop_front();
        cmp_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
        cmp_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
        cmp_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        cmp_field("done_res", 8'(want.done_res), 8'(got.done_res));
        cmp_field("rx_byte", want.rx_byte, got.rx_byte);
        cmp_field("ack_bit", 8'(want.ack_bit), 8'(got.ack_bit));
        beats_seen++;
    endtask
endclass

module i2c_bit_level_master_top_tb;

    localparam logic [KIND_W-1:0] KIND_SPARE = 3'd7;
    localparam logic [ACKM_W-1:0] ACKM_ACK   = 2'd1;
    localparam logic [ACKM_W-1:0] ACKM_SPARE = 2'd3;

    localparam int RANDOM_TICKS = 700;
    localparam int SQUEEZE_LEN  = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    // sda selection per command
    localparam int SDA_LOW  = 0;
    localparam int SDA_HIGH = 1;
    localparam int SDA_RAND = 2;

    logic i_clk;
    logic i_rst_n;

    i2cbm_in_if  in_ch ();
    i2cbm_out_if out_ch ();

    i2c_bit_level_master_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    bus_drive_scoreboard sb = new();

    int  src_gap_pct    = 26;
    int  sink_stall_pct = 81;
    int  tick_total     = 0;
    int  cycles         = 0;
    logic squeeze_on    = 1'b0;
    bit   squeeze_done  = 1'b0;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** i2c_bit_level_master_top: FAILED **");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (squeeze_on && !squeeze_done) begin
                squeeze_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (SQUEEZE_LEN) @(posedge i_clk);
            end else begin
                out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.scl_out  = out_ch.scl_out;
            got.sda_out  = out_ch.sda_out;
            got.busy_res = out_ch.busy_res;
            got.done_res = out_ch.done_res;
            got.rx_byte  = out_ch.rx_byte;
            got.ack_bit  = out_ch.ack_bit;
            sb.check_drive(got);
        end
    end

    function automatic logic pick_sda(int sel);
        if (sel == SDA_LOW)  return 1'b0;
        if (sel == SDA_HIGH) return 1'b1;
        return 1'(($urandom_range(1)));
    endfunction

    // valid stays up across back-to-back beats
    task automatic send_tick(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] tx,
                             logic [ACKM_W-1:0] am, logic s);
        while ($urandom_range(99) < src_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.kind     <= kind;
        in_ch.tx_byte  <= tx;
        in_ch.ack_mode <= am;
        in_ch.sda_in   <= s;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_tick(kind, tx, am, s);
        tick_total++;
    endtask

    // issue a command tick, then feed ticks until the sequence finishes;
    // kinds offered while busy are random and must be ignored
    task automatic run_command(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] tx,
                               logic [ACKM_W-1:0] am, int sel);
        send_tick(kind, tx, am, pick_sda(sel));
        while (!sb.idle())
            send_tick(KIND_W'($urandom_range(7)), BYTE_W'($urandom_range(255)),
                      ACKM_W'($urandom_range(3)), pick_sda(sel));
    endtask

    initial begin
        int                start_ticks;
        int                done_ticks;
        int                r;
        int                sel;
        logic [KIND_W-1:0] kind;

        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.kind     <= CMD_NONE;
        in_ch.tx_byte  <= '0;
        in_ch.ack_mode <= '0;
        in_ch.sda_in   <= 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle ticks, every command, edge bytes, both ack outcomes
        run_command(CMD_NONE, 8'h00, ACKM_NACK, SDA_HIGH);
        run_command(KIND_SPARE, 8'hFF, ACKM_SPARE, SDA_LOW);
        run_command(CMD_START, 8'h00, ACKM_NACK, SDA_RAND);
        run_command(CMD_SEND, 8'hFF, ACKM_NACK, SDA_HIGH);
        run_command(CMD_SEND, 8'h00, ACKM_NONE, SDA_LOW);
        run_command(CMD_SEND, 8'hA5, ACKM_SPARE, SDA_RAND);
        run_command(CMD_WAIT, 8'h00, ACKM_NACK, SDA_LOW);
        run_command(CMD_WAIT, 8'hFF, ACKM_ACK, SDA_HIGH);
        run_command(CMD_STOP, 8'h00, ACKM_NACK, SDA_RAND);
        run_command(CMD_READ, 8'h00, ACKM_NACK, SDA_HIGH);
        run_command(CMD_READ, 8'hFF, ACKM_ACK, SDA_LOW);
        run_command(CMD_READ, 8'h3C, ACKM_NONE, SDA_RAND);
        run_command(CMD_READ, 8'hC3, ACKM_SPARE, SDA_RAND);
        run_command(CMD_NONE, 8'h00, ACKM_NACK, SDA_LOW);
        run_command(CMD_PROBE, 8'h00, ACKM_NACK, SDA_LOW);
        run_command(CMD_PROBE, 8'hFF, ACKM_NONE, SDA_HIGH);
        run_command(CMD_PROBE, 8'h5A, ACKM_SPARE, SDA_RAND);
        run_command(CMD_START, 8'hFF, ACKM_ACK, SDA_HIGH);
        run_command(CMD_STOP, 8'hFF, ACKM_SPARE, SDA_LOW);

        start_ticks = tick_total;
        done_ticks  = 0;
        while (done_ticks < RANDOM_TICKS) begin
            if (done_ticks >= 2 * RANDOM_TICKS / 3) begin
                if (src_gap_pct != 0) begin
                    src_gap_pct    = 0;
                    sink_stall_pct = 0;
                    squeeze_on    <= 1'b1;
                end
            end else if (done_ticks >= RANDOM_TICKS / 3) begin
                src_gap_pct    = 81;
                sink_stall_pct = 26;
            end
            r = $urandom_range(99);
            if (r < 85)      kind = KIND_W'($urandom_range(CMD_PROBE, CMD_START));
            else if (r < 93) kind = CMD_NONE;
            else             kind = KIND_SPARE;
            r = $urandom_range(99);
            sel = (r < 10) ? SDA_LOW : (r < 20) ? SDA_HIGH : SDA_RAND;
            run_command(kind, BYTE_W'($urandom_range(255)), ACKM_W'($urandom_range(3)), sel);
            done_ticks = tick_total - start_ticks;
        end
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("** i2c_bit_level_master_top: PASSED **");
        end else begin
            $display("** i2c_bit_level_master_top: FAILED **");
        end
        $finish;
    end

endmodule
